// ===== rtl/ndts_pkg.sv =====
// ----------------------------------------------------------------------------
// ndts_pkg
// Shared constants, types and character decode for the name/data token
// splitter.
// ----------------------------------------------------------------------------
package ndts_pkg;

    localparam int MAX_TOKENS = 16;
    localparam int FIELD_LEN  = 32;

    localparam int CH_W    = 8;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 4;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 5;

    // token_index, text_char, char_pos, first_char, token_count; padded to bytes
    localparam int OUT_BITS = IDX_W + CH_W + POS_W + 1 + COUNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]   MAX_TOKENS_RESET = CFG_W'(10);
    localparam logic [CFG_W-1:0]   MAX_TOKENS_CAP   = CFG_W'(MAX_TOKENS);
    localparam logic [POS_W-1:0]   POS_LAST         = POS_W'(FIELD_LEN - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_NAME    = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_NAME = 2'd1,
        PEND_DATA = 2'd2
    } pend_t;

    typedef struct packed {
        logic is_nul;
        logic is_delim;
        logic mark_data;
        logic mark_name;
    } char_class_t;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_LF     = 8'h0A;

    function automatic logic is_delim(input logic [CH_W-1:0] c);
        is_delim = (c == CH_LT)    || (c == CH_LBRACE) || (c == CH_SPACE) ||
                   (c == CH_COLON) || (c == CH_EQUALS) || (c == CH_COMMA) ||
                   (c == CH_QUOTE) || (c == CH_TAB)    || (c == CH_SLASH) ||
                   (c == CH_RBRACE) || (c == CH_GT)    || (c == CH_CR)    ||
                   (c == CH_LF);
    endfunction

endpackage

// ===== rtl/ndts_char_class.sv =====
// ----------------------------------------------------------------------------
// ndts_char_class
// Classifies one character: end of text, delimiter, and type markers.
// ----------------------------------------------------------------------------
module ndts_char_class
    import ndts_pkg::*;
(
    input  logic [CH_W-1:0] ch,
    output char_class_t     cls
);

    always_comb begin
        cls.is_nul    = (ch == CH_NUL);
        cls.is_delim  = is_delim(ch);
        cls.mark_data = (ch == CH_EQUALS) || (ch == CH_COLON);
        cls.mark_name = (ch == CH_LBRACE);
    end

endmodule

// ===== rtl/name_data_token_splitter.sv =====
// ----------------------------------------------------------------------------
// name_data_token_splitter
// Splits a character stream into name and data tokens, one character per
// transfer, and emits each kept character plus a per-line summary.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                 tuser   tlast
//  s_        in   ch[7:0]               -       end_of_line
//  m_        out  idx,char,pos,first,n  kind    -
//  cfg_wr_*  in   max_tokens[4:0]       -       -
//
//  One character per cycle while s_tready is high: decode and state update sit between the line
//  state registers and the single output register.
//  Each input transfer gives at most one result, valid in the cycle after the transfer.
//  s_tready drops only while the output register holds an untaken result.
//  aresetn is synchronous, active low; max_tokens resets to 10.
// ----------------------------------------------------------------------------
module name_data_token_splitter
    import ndts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CH_W-1:0]    s_tdata,   // [7:0] ch
    input  logic               s_tlast,   // end_of_line

    output logic               m_tvalid,
    input  logic               m_tready,
    // [3:0] token_index, [11:4] text_char, [16:12] char_pos,
    // [17] first_char, [22:18] token_count, [23] zero
    output logic [OUT_W-1:0]   m_tdata,
    output logic [KIND_W-1:0]  m_tuser,   // [1:0] kind

    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    logic [CFG_W-1:0]   max_tokens_reg;
    logic               inside_reg,    inside_next;
    pend_t              pend_reg,      pend_next;
    logic               is_data_reg,   is_data_next;
    logic [COUNT_W-1:0] names_reg,     names_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic               halted_reg,    halted_next;

    logic               m_valid_reg,   m_valid_next;
    kind_t              kind_reg,      kind_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    logic [CH_W-1:0]    char_reg,      char_next;
    logic [POS_W-1:0]   opos_reg,      opos_next;
    logic               first_reg,     first_next;
    logic [COUNT_W-1:0] count_reg,     count_next;

    char_class_t        cls;
    logic               accept;
    logic               emit;
    logic [CFG_W-1:0]   limit;
    logic [COUNT_W-1:0] names_cur;

    ndts_char_class u_class (
        .ch  (s_tdata),
        .cls (cls)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign limit    = (max_tokens_reg > MAX_TOKENS_CAP) ? MAX_TOKENS_CAP : max_tokens_reg;

    always_comb begin
        inside_next  = inside_reg;
        pend_next    = pend_reg;
        is_data_next = is_data_reg;
        names_next   = names_reg;
        pos_next     = pos_reg;
        halted_next  = halted_reg;
        emit         = 1'b0;
        names_cur    = names_reg;
        kind_next    = is_data_reg ? KIND_DATA : KIND_NAME;
        char_next    = s_tdata;
        opos_next    = pos_reg;
        first_next   = 1'b0;
        count_next   = '0;

        if (accept) begin
            if (s_tlast) begin
                emit         = 1'b1;
                kind_next    = KIND_SUMMARY;
                char_next    = '0;
                opos_next    = '0;
                count_next   = names_reg;
                names_cur    = '0;
                inside_next  = 1'b0;
                pend_next    = PEND_NONE;
                is_data_next = 1'b0;
                names_next   = '0;
                pos_next     = '0;
                halted_next  = 1'b0;
            end else if (!halted_reg) begin
                if (cls.is_nul) begin
                    halted_next = 1'b1;
                    inside_next = 1'b0;
                end else if (cls.is_delim) begin
                    inside_next = 1'b0;
                    if (cls.mark_data) begin
                        pend_next = PEND_DATA;
                    end else if (cls.mark_name) begin
                        pend_next = PEND_NAME;
                    end
                end else if (!inside_reg) begin
                    if (CFG_W'(names_reg) >= limit) begin
                        halted_next = 1'b1;
                    end else begin
                        emit         = 1'b1;
                        is_data_next = (pend_reg == PEND_DATA);
                        if (pend_reg != PEND_DATA) begin
                            names_next = names_reg + COUNT_W'(1);
                        end
                        names_cur   = names_next;
                        kind_next   = (pend_reg == PEND_DATA) ? KIND_DATA : KIND_NAME;
                        opos_next   = '0;
                        first_next  = 1'b1;
                        pend_next   = PEND_NONE;
                        inside_next = 1'b1;
                        pos_next    = POS_W'(1);
                    end
                end else if (pos_reg < POS_LAST) begin
                    emit     = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end

        // entry index: names_seen - 1, or 0 before any name and for a summary
        idx_next = (names_cur == '0 || kind_next == KIND_SUMMARY)
                   ? '0 : IDX_W'(names_cur - COUNT_W'(1));

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tokens_reg <= MAX_TOKENS_RESET;
            inside_reg     <= 1'b0;
            pend_reg       <= PEND_NONE;
            is_data_reg    <= 1'b0;
            names_reg      <= '0;
            pos_reg        <= '0;
            halted_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_tokens_reg <= cfg_wr_data;
            end
            inside_reg  <= inside_next;
            pend_reg    <= pend_next;
            is_data_reg <= is_data_next;
            names_reg   <= names_next;
            pos_reg     <= pos_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            char_reg  <= char_next;
            opos_reg  <= opos_next;
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}},
                       count_reg, first_reg, opos_reg, char_reg, idx_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_names_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        names_reg <= COUNT_W'(MAX_TOKENS))
        else $error("name count above token limit");

    a_halt_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !inside_reg)
        else $error("token open while scan halted");

    a_open_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        inside_reg |-> (pos_reg != '0))
        else $error("open token with zero position");

    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (names_reg == '0 && !halted_reg && !inside_reg
                                 && m_valid_reg && kind_reg == KIND_SUMMARY))
        else $error("end of line did not clear line state");

endmodule

// ===== tb/sv/tb_name_data_token_splitter.sv =====
// ----------------------------------------------------------------------------
// tb_name_data_token_splitter
// Self-checking bench for the name/data token splitter. A short directed
// table walks every delimiter, marker precedence, data before any name, NUL
// and end of line. Random lines then run under several max_tokens settings
// with random gaps and stalls on both streams. Every result transfer is
// checked against its directed expectation or a predictor of the line scanner.
// ----------------------------------------------------------------------------
module tb_name_data_token_splitter;
    import ndts_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BUDGET = 225;
    localparam int NUM_PHASES   = 7;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   idx;
        logic [CH_W-1:0]    text;
        logic [POS_W-1:0]   pos;
        logic               first;
        logic [COUNT_W-1:0] count;
    } token_out_t;

    typedef struct {
        logic [CH_W-1:0] ch;
        bit              eol;
        bit              typed;
        token_out_t      exp;
    } stim_t;

    localparam token_out_t NO_EXP = '0;
    localparam logic [CH_W-1:0] SEPARATORS [13] = '{
        CH_LT, CH_LBRACE, CH_SPACE, CH_COLON, CH_EQUALS, CH_COMMA, CH_QUOTE,
        CH_TAB, CH_SLASH, CH_RBRACE, CH_GT, CH_CR, CH_LF
    };

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [CH_W-1:0]    s_tdata     = '0;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;

    // expectation attached to the item currently offered
    logic               s_typed     = 1'b0;
    token_out_t         s_exp       = '0;

    name_data_token_splitter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line scanner predictor
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   lim_cfg;
    bit                 in_token;
    pend_t              marker;
    bit                 is_data_tok;
    logic [COUNT_W-1:0] name_cnt;
    logic [POS_W-1:0]   next_pos;
    bit                 halted;

    token_out_t token_results_q[$];
    stim_t      stim_q[$];

    int  mismatches    = 0;
    int  items_in      = 0;
    int  chars_checked = 0;
    int  lines_checked = 0;
    int  idle_cycles   = 0;
    bit  burst         = 1'b0;
    bit  hold_off_req  = 1'b0;
    bit  hold_done     = 1'b0;

    function automatic bit is_separator(input logic [CH_W-1:0] c);
        foreach (SEPARATORS[i])
            if (SEPARATORS[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    function void clear_line_state();
        in_token    = 1'b0;
        marker      = PEND_NONE;
        is_data_tok = 1'b0;
        name_cnt    = '0;
        next_pos    = '0;
        halted      = 1'b0;
    endfunction

    function automatic bit predict_token(input logic [CH_W-1:0] c, input bit eol,
                                         output token_out_t r);
        logic [CFG_W-1:0] lim;
        r = '0;
        if (eol) begin
            r.kind  = KIND_SUMMARY;
            r.count = name_cnt;
            clear_line_state();
            return 1'b1;
        end
        if (halted) return 1'b0;
        if (c == CH_NUL) begin
            halted   = 1'b1;
            in_token = 1'b0;
            return 1'b0;
        end
        if (is_separator(c)) begin
            in_token = 1'b0;
            if (c == CH_EQUALS || c == CH_COLON)
                marker = PEND_DATA;
            else if (c == CH_LBRACE)
                marker = PEND_NAME;
            return 1'b0;
        end
        if (!in_token) begin
            lim = (lim_cfg > MAX_TOKENS_CAP) ? MAX_TOKENS_CAP : lim_cfg;
            if (name_cnt >= lim) begin
                halted = 1'b1;
                return 1'b0;
            end
            if (marker == PEND_DATA) begin
                is_data_tok = 1'b1;
            end else begin
                is_data_tok = 1'b0;
                name_cnt    = name_cnt + COUNT_W'(1);
            end
            marker   = PEND_NONE;
            in_token = 1'b1;
            next_pos = '0;
        end else if (next_pos >= POS_LAST) begin
            return 1'b0;  // long token: tail is dropped
        end
        r.kind  = is_data_tok ? KIND_DATA : KIND_NAME;
        r.idx   = (name_cnt == 0) ? '0 : IDX_W'(name_cnt - COUNT_W'(1));
        r.text  = c;
        r.pos   = next_pos;
        r.first = (next_pos == 0);
        next_pos = next_pos + POS_W'(1);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check result transfers, then predict from input transfers
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        token_out_t act;
        token_out_t exp;
        token_out_t pred;
        if (!aresetn) begin
            lim_cfg = MAX_TOKENS_RESET;
            clear_line_state();
        end else begin
            if (m_tvalid && m_tready) begin
                act.kind  = kind_t'(m_tuser);
                act.idx   = m_tdata[3:0];
                act.text  = m_tdata[11:4];
                act.pos   = m_tdata[16:12];
                act.first = m_tdata[17];
                act.count = m_tdata[22:18];
                if (token_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d idx %0d ch %02h pos %0d",
                                 act.kind, act.idx, act.text, act.pos);
                end else begin
                    exp = token_results_q.pop_front();
                    if (act.kind == KIND_SUMMARY) lines_checked++;
                    else chars_checked++;
                    if (act.kind !== exp.kind || act.idx !== exp.idx ||
                        act.text !== exp.text || act.pos !== exp.pos ||
                        act.first !== exp.first || act.count !== exp.count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp kind %0d idx %0d ch %02h pos %0d first %0b count %0d",
                                     exp.kind, exp.idx, exp.text, exp.pos, exp.first,
                                     exp.count);
                            $display("          got kind %0d idx %0d ch %02h pos %0d first %0b count %0d",
                                     act.kind, act.idx, act.text, act.pos, act.first,
                                     act.count);
                        end
                    end
                end
            end
            if (cfg_wr_en)
                lim_cfg = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                items_in++;
                if (predict_token(s_tdata, s_tlast, pred))
                    token_results_q.push_back(s_typed ? s_exp : pred);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("name_data_token_splitter regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stream receiver
    // ------------------------------------------------------------------
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            stall = burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic stim_t row(input logic [CH_W-1:0] c, input bit eol,
                                  input bit typed = 1'b0, input token_out_t exp = NO_EXP);
        stim_t s;
        s.ch    = c;
        s.eol   = eol;
        s.typed = typed;
        s.exp   = exp;
        return s;
    endfunction

    function automatic token_out_t first_char_exp(input kind_t k, input int idx,
                                                  input logic [CH_W-1:0] c);
        token_out_t r;
        r       = '0;
        r.kind  = k;
        r.idx   = IDX_W'(idx);
        r.text  = c;
        r.first = 1'b1;
        return r;
    endfunction

    function automatic token_out_t summary_exp(input int n);
        token_out_t r;
        r       = '0;
        r.kind  = KIND_SUMMARY;
        r.count = COUNT_W'(n);
        return r;
    endfunction

    function automatic logic [CH_W-1:0] token_byte();
        logic [CH_W-1:0] c;
        if ($urandom_range(0, 1) == 0)
            return CH_W'($urandom_range(97, 122));
        do c = CH_W'($urandom_range(1, 255)); while (is_separator(c));
        return c;
    endfunction

    function automatic logic [CH_W-1:0] separator_byte();
        case ($urandom_range(0, 5))
            0:       return CH_EQUALS;
            1:       return CH_COLON;
            2:       return CH_LBRACE;
            default: return SEPARATORS[$urandom_range(0, 12)];
        endcase
    endfunction

    // one line of delimiter runs and tokens, now and then broken by noise
    task automatic add_random_line();
        int ntok;
        int run;
        int len;
        ntok = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 19) : $urandom_range(0, 6);
        for (int t = 0; t < ntok; t++) begin
            run = (t == 0) ? $urandom_range(0, 2) : $urandom_range(1, 3);
            repeat (run) stim_q.push_back(row(separator_byte(), 1'b0));
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
            repeat (len) stim_q.push_back(row(token_byte(), 1'b0));
            if ($urandom_range(0, 39) == 0)
                stim_q.push_back(row(CH_W'($urandom_range(0, 255)), 1'b0));
            if ($urandom_range(0, 59) == 0)
                stim_q.push_back(row(CH_NUL, 1'b0));
        end
        if ($urandom_range(0, 14) != 0)
            stim_q.push_back(row(CH_W'($urandom_range(0, 255)), 1'b1));
    endtask

    task automatic send_item(input stim_t s);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s.ch;
        s_tlast  <= s.eol;
        s_typed  <= s.typed;
        s_exp    <= s.exp;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_queue(input bit pressure);
        stim_t s;
        while (stim_q.size() != 0) begin
            s = stim_q.pop_front();
            send_item(s);
            if (!pressure && s.eol)
                burst = ($urandom_range(0, 3) == 0);
        end
    endtask

    // wait for the block to go idle; at most one result per transfer
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (token_results_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_max_tokens(input int v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        stim_t dir_table[$];
        int    plan[NUM_PHASES];

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed line set, run with max_tokens at its reset value
        dir_table.push_back(row(8'h41, 1'b1, 1'b1, summary_exp(0)));
        dir_table.push_back(row(CH_COLON, 1'b0));
        dir_table.push_back(row(8'hFF, 1'b0, 1'b1, first_char_exp(KIND_DATA, 0, 8'hFF)));
        dir_table.push_back(row(8'h01, 1'b0));
        dir_table.push_back(row(CH_SPACE, 1'b0));
        dir_table.push_back(row("a", 1'b0, 1'b1, first_char_exp(KIND_NAME, 0, "a")));
        dir_table.push_back(row(CH_EQUALS, 1'b0));
        dir_table.push_back(row(CH_COLON, 1'b0));
        // last marker of the run wins
        dir_table.push_back(row(CH_LBRACE, 1'b0));
        dir_table.push_back(row(8'h80, 1'b0, 1'b1, first_char_exp(KIND_NAME, 1, 8'h80)));
        dir_table.push_back(row(CH_COMMA, 1'b0));
        dir_table.push_back(row(CH_EQUALS, 1'b0));
        dir_table.push_back(row("q", 1'b0));
        dir_table.push_back(row(CH_LT, 1'b0));
        dir_table.push_back(row(CH_QUOTE, 1'b0));
        dir_table.push_back(row(CH_TAB, 1'b0));
        dir_table.push_back(row(CH_SLASH, 1'b0));
        dir_table.push_back(row(CH_RBRACE, 1'b0));
        dir_table.push_back(row(CH_GT, 1'b0));
        dir_table.push_back(row(CH_CR, 1'b0));
        dir_table.push_back(row(CH_LF, 1'b0));
        dir_table.push_back(row(8'h7F, 1'b0));
        // NUL ends the text; the rest of the line is ignored
        dir_table.push_back(row(CH_NUL, 1'b0));
        dir_table.push_back(row("x", 1'b0));
        dir_table.push_back(row(8'h00, 1'b1, 1'b1, summary_exp(3)));
        foreach (dir_table[i])
            send_item(dir_table[i]);
        drain();

        plan = '{31, 16, 1, 0, $urandom_range(2, 15), 10, $urandom_range(0, 31)};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_max_tokens(plan[p]);
            while (stim_q.size() < PHASE_BUDGET) add_random_line();
            stim_q.push_back(row(CH_W'($urandom_range(0, 255)), 1'b1));
            if (p == 1) begin
                // receiver holds off while the sender keeps offering
                burst        = 1'b1;
                hold_off_req = 1'b1;
            end
            send_queue(p == 1);
            burst = 1'b0;
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("covered %0d input transfers: %0d token characters, %0d line summaries",
                 items_in, chars_checked, lines_checked);
        $display("over %0d max_tokens settings, %0d mismatches", NUM_PHASES + 1, mismatches);
        if (mismatches == 0 && token_results_q.size() == 0) begin
            $display("name_data_token_splitter regression: pass");
        end else begin
            $display("name_data_token_splitter regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ndts_pkg.sv
rtl/ndts_char_class.sv
rtl/name_data_token_splitter.sv
tb/sv/tb_name_data_token_splitter.sv
